@@ rtl/rff_pkg.sv @@
// ----------------------------------------------------------------------------
// rff_pkg
// Shared constants, types and register codes for the reflection fade factor
// pipeline.
// ----------------------------------------------------------------------------
package rff_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int VAL_W      = FRAC_BITS + 1;
    localparam int FIELD_W    = 16;
    localparam int WIDE_W     = FIELD_W + 2;
    localparam int CFG_W      = 15;
    localparam int EPS_W      = 12;
    localparam int IDX_W      = 2;
    localparam int NUM_LANES  = 4;
    localparam int IN_DATA_W  = 4 * FIELD_W;
    localparam int OUT_DATA_W = ((VAL_W + 7) / 8) * 8;

    localparam int LANE_U    = 0;
    localparam int LANE_V    = 1;
    localparam int LANE_DIST = 2;
    localparam int LANE_BACK = 3;

    localparam logic [VAL_W-1:0] ONE       = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [VAL_W-1:0] HALF      = ONE >> 1;
    localparam logic [VAL_W-1:0] QUARTER   = ONE >> 2;
    localparam logic [VAL_W:0]   THREE_ONE = {2'b11, {FRAC_BITS{1'b0}}};

    localparam logic [IDX_W-1:0] REG_EDGE_BORDER   = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_DIST_FRACTION = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_BACK_EPS      = IDX_W'(2);

    localparam logic [CFG_W-1:0] EDGE_BORDER_RST   = CFG_W'(1638);
    localparam logic [CFG_W-1:0] DIST_FRACTION_RST = CFG_W'(3277);
    localparam logic [EPS_W-1:0] BACK_EPS_RST      = EPS_W'(164);

    typedef logic [VAL_W-1:0] ufix_t;

    typedef struct packed {
        ufix_t                rem;
        ufix_t                den;
        logic [FRAC_BITS-1:0] quo;
        logic                 sat;
    } div_lane_t;

    typedef div_lane_t [NUM_LANES-1:0] div_set_t;
    typedef ufix_t [NUM_LANES-1:0] fade_set_t;

    typedef struct packed {
        logic [CFG_W-1:0] edge_border;
        logic [CFG_W-1:0] dist_fraction;
        logic [EPS_W-1:0] back_eps;
    } cfg_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] hit_u;
        logic signed [FIELD_W-1:0] hit_v;
        logic signed [FIELD_W-1:0] march_fraction;
        logic signed [FIELD_W-1:0] reflect_z;
    } pixel_t;

endpackage

@@ rtl/rff_prep.sv @@
// ----------------------------------------------------------------------------
// rff_prep
// Input stage: folds each fade into a band position, a divisor and a
// saturation flag for the shared divider lanes.
// ----------------------------------------------------------------------------
module rff_prep (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  rff_pkg::pixel_t   in_pixel,
    input  rff_pkg::cfg_t     cfg,
    output logic              out_valid,
    output rff_pkg::div_set_t out_lanes
);

    localparam int PAD_W = rff_pkg::WIDE_W - rff_pkg::VAL_W;

    logic              valid_reg;
    rff_pkg::div_set_t lanes_reg;
    rff_pkg::div_set_t lanes_next;

    function automatic logic signed [rff_pkg::WIDE_W-1:0] widen_u(input rff_pkg::ufix_t x);
        widen_u = $signed({{PAD_W{1'b0}}, x});
    endfunction

    function automatic logic signed [rff_pkg::WIDE_W-1:0] widen_s(
        input logic signed [rff_pkg::FIELD_W-1:0] x
    );
        widen_s = $signed({{(rff_pkg::WIDE_W - rff_pkg::FIELD_W){x[rff_pkg::FIELD_W-1]}}, x});
    endfunction

    function automatic rff_pkg::div_lane_t lane_make(
        input logic signed [rff_pkg::WIDE_W-1:0] num,
        input rff_pkg::ufix_t                    den,
        input logic                              force_zero,
        input logic                              force_sat
    );
        rff_pkg::div_lane_t l;
        l.rem = '0;
        l.den = rff_pkg::ONE;
        l.quo = '0;
        l.sat = 1'b0;
        if (force_sat)
        begin
            l.sat = 1'b1;
        end
        else if (force_zero || num[rff_pkg::WIDE_W-1] || (num == '0))
        begin
            l.sat = 1'b0;
        end
        else if (num >= widen_u(den))
        begin
            l.sat = 1'b1;
        end
        else
        begin
            l.rem = num[rff_pkg::VAL_W-1:0];
            l.den = den;
        end
        return l;
    endfunction

    function automatic rff_pkg::div_lane_t edge_lane(
        input logic signed [rff_pkg::FIELD_W-1:0] c,
        input logic [rff_pkg::CFG_W-1:0]          border
    );
        logic signed [rff_pkg::WIDE_W-1:0] cw;
        logic signed [rff_pkg::WIDE_W-1:0] band_pos;
        logic                              on_screen;
        cw        = widen_s(c);
        band_pos  = (cw < widen_u(rff_pkg::HALF)) ? cw : widen_u(rff_pkg::ONE) - cw;
        on_screen = !cw[rff_pkg::WIDE_W-1] && (cw <= widen_u(rff_pkg::ONE));
        if (border == '0)
        begin
            return lane_make(band_pos, rff_pkg::ONE, !on_screen, on_screen);
        end
        return lane_make(band_pos, rff_pkg::ufix_t'(border), 1'b0, 1'b0);
    endfunction

    function automatic rff_pkg::div_lane_t dist_lane(
        input logic signed [rff_pkg::FIELD_W-1:0] t,
        input logic [rff_pkg::CFG_W-1:0]          frac
    );
        logic signed [rff_pkg::WIDE_W-1:0] tw;
        logic signed [rff_pkg::WIDE_W-1:0] tt;
        logic signed [rff_pkg::WIDE_W-1:0] nd;
        rff_pkg::ufix_t                    fc;
        tw = widen_s(t);
        if (tw[rff_pkg::WIDE_W-1])
        begin
            tt = '0;
        end
        else if (tw > widen_u(rff_pkg::ONE))
        begin
            tt = widen_u(rff_pkg::ONE);
        end
        else
        begin
            tt = tw;
        end
        fc = (rff_pkg::ufix_t'(frac) > rff_pkg::ONE) ? rff_pkg::ONE : rff_pkg::ufix_t'(frac);
        nd = tt - (widen_u(rff_pkg::ONE) - widen_u(fc));
        return lane_make(nd, fc, frac == '0, 1'b0);
    endfunction

    function automatic rff_pkg::div_lane_t back_lane(
        input logic signed [rff_pkg::FIELD_W-1:0] z,
        input logic [rff_pkg::EPS_W-1:0]          eps
    );
        logic signed [rff_pkg::WIDE_W-1:0] num;
        rff_pkg::ufix_t                    epsu;
        epsu = rff_pkg::ufix_t'(eps);
        num  = -widen_s(z) - widen_u(epsu);
        return lane_make(num, rff_pkg::QUARTER - epsu, 1'b0, 1'b0);
    endfunction

    always_comb
    begin
        lanes_next[rff_pkg::LANE_U]    = edge_lane(in_pixel.hit_u, cfg.edge_border);
        lanes_next[rff_pkg::LANE_V]    = edge_lane(in_pixel.hit_v, cfg.edge_border);
        lanes_next[rff_pkg::LANE_DIST] = dist_lane(in_pixel.march_fraction, cfg.dist_fraction);
        lanes_next[rff_pkg::LANE_BACK] = back_lane(in_pixel.reflect_z, cfg.back_eps);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lanes_reg <= lanes_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lanes = lanes_reg;

endmodule

@@ rtl/rff_div.sv @@
// ----------------------------------------------------------------------------
// rff_div
// Pipelined restoring divider, one quotient bit per stage, four lanes wide.
// ----------------------------------------------------------------------------
module rff_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  rff_pkg::div_set_t in_lanes,
    output logic              out_valid,
    output rff_pkg::div_set_t out_lanes
);

    localparam int STAGES = rff_pkg::FRAC_BITS;

    logic [STAGES-1:0] valid_reg;
    rff_pkg::div_set_t stage_reg [STAGES];

    function automatic rff_pkg::div_lane_t lane_step(input rff_pkg::div_lane_t l);
        rff_pkg::div_lane_t     o;
        logic [rff_pkg::VAL_W:0] r2;
        logic                    q;
        o  = l;
        r2 = {l.rem, 1'b0};
        q  = 1'b0;
        if (r2 >= {1'b0, l.den})
        begin
            r2 = r2 - {1'b0, l.den};
            q  = 1'b1;
        end
        o.rem = r2[rff_pkg::VAL_W-1:0];
        o.quo = {l.quo[rff_pkg::FRAC_BITS-2:0], q};
        return o;
    endfunction

    function automatic rff_pkg::div_set_t set_step(input rff_pkg::div_set_t s);
        rff_pkg::div_set_t o;
        for (int i = 0; i < rff_pkg::NUM_LANES; i++)
        begin
            o[i] = lane_step(s[i]);
        end
        return o;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= set_step(in_lanes);
            for (int k = 1; k < STAGES; k++)
            begin
                stage_reg[k] <= set_step(stage_reg[k-1]);
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_lanes = stage_reg[STAGES-1];

`ifndef ASSERT_OFF
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (out_lanes[rff_pkg::LANE_U].rem < out_lanes[rff_pkg::LANE_U].den) &&
            (out_lanes[rff_pkg::LANE_V].rem < out_lanes[rff_pkg::LANE_V].den) &&
            (out_lanes[rff_pkg::LANE_DIST].rem < out_lanes[rff_pkg::LANE_DIST].den) &&
            (out_lanes[rff_pkg::LANE_BACK].rem < out_lanes[rff_pkg::LANE_BACK].den))
        else $error("divider remainder not below divisor");
`endif

endmodule

@@ rtl/rff_smooth.sv @@
// ----------------------------------------------------------------------------
// rff_smooth
// Two-stage smoothstep on the band positions of all four lanes.
// ----------------------------------------------------------------------------
module rff_smooth (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  rff_pkg::div_set_t  in_lanes,
    output logic               out_valid,
    output rff_pkg::fade_set_t out_fade
);

    localparam int N = rff_pkg::NUM_LANES;
    localparam int F = rff_pkg::FRAC_BITS;
    localparam int W = rff_pkg::VAL_W;

    logic                          a_valid_reg;
    logic                          b_valid_reg;
    rff_pkg::ufix_t [N-1:0]        t_lane;
    logic [N-1:0][2*W-1:0]         sq_full;
    rff_pkg::ufix_t [N-1:0]        sq_next;
    rff_pkg::ufix_t [N-1:0]        sq_reg;
    logic [N-1:0][W:0]             slope_next;
    logic [N-1:0][W:0]             slope_reg;
    logic [N-1:0][2*W:0]           prod;
    rff_pkg::fade_set_t            fade_next;
    rff_pkg::fade_set_t            fade_reg;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            t_lane[i]     = in_lanes[i].sat ? rff_pkg::ONE : {1'b0, in_lanes[i].quo};
            sq_full[i]    = {{W{1'b0}}, t_lane[i]} * {{W{1'b0}}, t_lane[i]};
            sq_next[i]    = sq_full[i][F +: W];
            slope_next[i] = rff_pkg::THREE_ONE - {t_lane[i], 1'b0};
            prod[i]       = {{(W+1){1'b0}}, sq_reg[i]} * {{W{1'b0}}, slope_reg[i]};
            fade_next[i]  = prod[i][F +: W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg    <= sq_next;
            slope_reg <= slope_next;
            fade_reg  <= fade_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_fade  = fade_reg;

endmodule

@@ rtl/rff_combine.sv @@
// ----------------------------------------------------------------------------
// rff_combine
// Combines the edge, distance and backface fades into the weight and holds
// the result register; also produces the pipeline advance enable.
// ----------------------------------------------------------------------------
module rff_combine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  rff_pkg::fade_set_t in_fade,
    input  logic               m_tready,
    output logic               en,
    output logic               m_tvalid,
    output rff_pkg::ufix_t     weight
);

    localparam int F = rff_pkg::FRAC_BITS;
    localparam int W = rff_pkg::VAL_W;

    logic             c_valid_reg;
    logic             d_valid_reg;
    logic             out_valid_reg;
    rff_pkg::ufix_t   e_next;
    rff_pkg::ufix_t   e_reg;
    rff_pkg::ufix_t   d_next;
    rff_pkg::ufix_t   d_reg;
    rff_pkg::ufix_t   b_reg;
    logic [2*W-1:0]   ed_full;
    rff_pkg::ufix_t   ed_reg;
    rff_pkg::ufix_t   bd_reg;
    logic [2*W-1:0]   w_full;
    rff_pkg::ufix_t   weight_next;
    rff_pkg::ufix_t   weight_reg;
    logic             load;

    assign en   = !d_valid_reg || !out_valid_reg || m_tready;
    assign load = d_valid_reg && (!out_valid_reg || m_tready);

    always_comb
    begin
        e_next = (in_fade[rff_pkg::LANE_U] < in_fade[rff_pkg::LANE_V]) ?
                 in_fade[rff_pkg::LANE_U] : in_fade[rff_pkg::LANE_V];
        d_next      = rff_pkg::ONE - in_fade[rff_pkg::LANE_DIST];
        ed_full     = {{W{1'b0}}, e_reg} * {{W{1'b0}}, d_reg};
        w_full      = {{W{1'b0}}, ed_reg} * {{W{1'b0}}, bd_reg};
        weight_next = w_full[F +: W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                c_valid_reg <= in_valid;
                d_valid_reg <= c_valid_reg;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg  <= e_next;
            d_reg  <= d_next;
            b_reg  <= in_fade[rff_pkg::LANE_BACK];
            ed_reg <= ed_full[F +: W];
            bd_reg <= b_reg;
        end
        if (load)
        begin
            weight_reg <= weight_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign weight   = weight_reg;

`ifndef ASSERT_OFF
    a_weight_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (weight_reg <= rff_pkg::ONE))
        else $error("fade weight above one");

    a_factors_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> (e_reg <= rff_pkg::ONE) && (d_reg <= rff_pkg::ONE) &&
                        (b_reg <= rff_pkg::ONE))
        else $error("fade factor above one");

    a_last_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid_reg && out_valid_reg && !m_tready) |=> d_valid_reg)
        else $error("pending request dropped while output stalled");
`endif

endmodule

@@ rtl/reflection_fade_factor.sv @@
// ----------------------------------------------------------------------------
// reflection_fade_factor
// Path from an accepted request to m_tvalid: input stage, 14 divider stages,
// 2 smoothstep stages, 2 combine stages, output register; the divider
// pipeline sets the depth. One request per cycle unless the output stalls.
// Reset clears all valid bits and loads the register defaults at once.
// ----------------------------------------------------------------------------
module reflection_fade_factor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // hit_u[15:0], hit_v[31:16], march_fraction[47:32], reflect_z[63:48]
    input  logic [rff_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // fade_weight[14:0], zero pad[15]
    output logic [rff_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rff_pkg::IDX_W-1:0]           cfg_index,
    input  logic [rff_pkg::CFG_W-1:0]           cfg_data
);

    localparam int FW = rff_pkg::FIELD_W;

    rff_pkg::cfg_t      cfg_reg;
    rff_pkg::pixel_t    pixel;
    logic               en;
    logic               prep_valid;
    rff_pkg::div_set_t  prep_lanes;
    logic               div_valid;
    rff_pkg::div_set_t  div_lanes;
    logic               smooth_valid;
    rff_pkg::fade_set_t smooth_fade;
    rff_pkg::ufix_t     weight;

    assign cfg_ready = 1'b1;
    assign s_tready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.edge_border   <= rff_pkg::EDGE_BORDER_RST;
            cfg_reg.dist_fraction <= rff_pkg::DIST_FRACTION_RST;
            cfg_reg.back_eps      <= rff_pkg::BACK_EPS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rff_pkg::REG_EDGE_BORDER:   cfg_reg.edge_border   <= cfg_data;
                rff_pkg::REG_DIST_FRACTION: cfg_reg.dist_fraction <= cfg_data;
                rff_pkg::REG_BACK_EPS:      cfg_reg.back_eps      <= cfg_data[rff_pkg::EPS_W-1:0];
                default:                    cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        pixel.hit_u          = $signed(s_tdata[FW-1:0]);
        pixel.hit_v          = $signed(s_tdata[2*FW-1:FW]);
        pixel.march_fraction = $signed(s_tdata[3*FW-1:2*FW]);
        pixel.reflect_z      = $signed(s_tdata[4*FW-1:3*FW]);
    end

    rff_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_pixel  (pixel),
        .cfg       (cfg_reg),
        .out_valid (prep_valid),
        .out_lanes (prep_lanes)
    );

    rff_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .in_lanes  (prep_lanes),
        .out_valid (div_valid),
        .out_lanes (div_lanes)
    );

    rff_smooth u_smooth (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_lanes  (div_lanes),
        .out_valid (smooth_valid),
        .out_fade  (smooth_fade)
    );

    rff_combine u_combine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (smooth_valid),
        .in_fade  (smooth_fade),
        .m_tready (m_tready),
        .en       (en),
        .m_tvalid (m_tvalid),
        .weight   (weight)
    );

    assign m_tdata = {{(rff_pkg::OUT_DATA_W - rff_pkg::VAL_W){1'b0}}, weight};

endmodule

@@ tb/reflection_fade_factor_tb.sv @@
// ----------------------------------------------------------------------------
// reflection_fade_factor_tb
// Self-checking bench for the reflection fade weight pipeline. Pixel requests
// go in through the slave stream; a bit-exact fixed-point predictor computes
// the weight for each accepted request and the monitor compares every result
// with the oldest pending prediction. The run covers field extremes, register
// settings at their limits, long random traffic with bursty input and a
// stalling output, and a long output hold that backs up the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module reflection_fade_factor_tb;

    import rff_pkg::*;

    localparam longint UNIT         = longint'(1) << FRAC_BITS;
    localparam int     DRAIN_CYCLES = 25;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     MAX_REPORTS  = 50;

    localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(3);

    typedef struct {
        pixel_t           px;
        logic [VAL_W-1:0] weight;
    } fade_req_t;

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  s_tvalid   = 1'b0;
    logic                  s_tready;
    // hit_u[15:0], hit_v[31:16], march_fraction[47:32], reflect_z[63:48]
    logic [IN_DATA_W-1:0]  s_tdata    = '0;
    logic                  m_tvalid;
    logic                  m_tready   = 1'b0;
    // fade_weight[14:0], zero pad[15]
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index  = '0;
    logic [CFG_W-1:0]      cfg_data   = '0;

    cfg_t      fade_cfg;
    fade_req_t pending_fades[$];
    fade_req_t head_req;
    int        mismatch_count = 0;

    bit        tx_gaps        = 1'b0;
    int        tx_burst_left  = 0;
    int        rx_stall_pct   = 0;
    logic      rx_hold        = 1'b0;
    logic [7:0] rx_pattern    = 8'b1011_0110;

    reflection_fade_factor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("reflection_fade_factor verification failed");
        $finish;
    end

    function automatic longint unit_clamp(longint x);
        return x < 0 ? 0 : (x > UNIT ? UNIT : x);
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b) >> FRAC_BITS;
    endfunction

    function automatic longint smooth_ramp(longint lo, longint hi, longint x);
        longint r;
        if (hi <= lo)
            return x < lo ? 0 : UNIT;
        r = unit_clamp(((x - lo) * UNIT) / (hi - lo));
        return qmul(qmul(r, r), 3 * UNIT - 2 * r);
    endfunction

    function automatic logic [VAL_W-1:0] predict_fade(pixel_t px, cfg_t c);
        longint u, v, t, z, border, frac, eps;
        longint du, dv, fu, fv, e, d, b;
        u      = px.hit_u;
        v      = px.hit_v;
        t      = px.march_fraction;
        z      = px.reflect_z;
        border = c.edge_border;
        frac   = c.dist_fraction;
        eps    = c.back_eps;
        if (border == 0)
            e = (u < 0 || u > UNIT || v < 0 || v > UNIT) ? 0 : UNIT;
        else
        begin
            du = u < UNIT / 2 ? u : UNIT - u;
            dv = v < UNIT / 2 ? v : UNIT - v;
            fu = smooth_ramp(0, border, du);
            fv = smooth_ramp(0, border, dv);
            e  = unit_clamp(fu < fv ? fu : fv);
        end
        if (frac == 0)
            d = UNIT;
        else
            d = UNIT - smooth_ramp(UNIT - unit_clamp(frac), UNIT, unit_clamp(t));
        if (z >= -eps)
            b = 0;
        else
            b = smooth_ramp(eps, UNIT / 4, -z);
        return VAL_W'(unit_clamp(qmul(qmul(unit_clamp(e), unit_clamp(d)), unit_clamp(b))));
    endfunction

    function automatic pixel_t make_pixel(int u, int v, int t, int z);
        pixel_t px;
        px.hit_u          = FIELD_W'(u);
        px.hit_v          = FIELD_W'(v);
        px.march_fraction = FIELD_W'(t);
        px.reflect_z      = FIELD_W'(z);
        return px;
    endfunction

    function automatic int random_coord();
        case ($urandom_range(0, 3))
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: return ($urandom_range(0, 1) ? int'(UNIT) : 0)
                      + int'($urandom_range(0, 4096)) - 2048;
            default: return int'($urandom_range(0, 16384));
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        int t, z;
        case ($urandom_range(0, 3))
            0: t = int'($urandom_range(0, 65535)) - 32768;
            1: t = 16384 - int'($urandom_range(0, 4000));
            default: t = int'($urandom_range(0, 16384));
        endcase
        case ($urandom_range(0, 3))
            0: z = int'($urandom_range(0, 65535)) - 32768;
            1: z = -int'(fade_cfg.back_eps) + int'($urandom_range(0, 16)) - 8;
            default: z = -int'($urandom_range(0, 16384));
        endcase
        return make_pixel(random_coord(), random_coord(), t, z);
    endfunction

    function automatic int unsigned random_setting(int unsigned hi);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return hi;
            2: return 1;
            default: return $urandom_range(0, hi);
        endcase
    endfunction

    task automatic report_mismatch(string what, pixel_t px, logic [VAL_W-1:0] got,
                                   logic [VAL_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH %0t: %s u=%0d v=%0d t=%0d z=%0d got=%0d want=%0d",
                     $realtime, what, px.hit_u, px.hit_v, px.march_fraction,
                     px.reflect_z, got, want);
    endtask

    task automatic send_pixel(pixel_t px);
        fade_req_t req;
        s_tvalid <= 1'b1;
        s_tdata  <= {px.reflect_z, px.march_fraction, px.hit_v, px.hit_u};
        do
            @(posedge clk);
        while (!s_tready);
        req.px     = px;
        req.weight = predict_fade(px, fade_cfg);
        pending_fades.push_back(req);
        if (tx_gaps)
        begin
            if (tx_burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                tx_burst_left = $urandom_range(1, 24);
            end
            else
                tx_burst_left--;
        end
    endtask

    task automatic wait_idle();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (pending_fades.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_EDGE_BORDER:   fade_cfg.edge_border   = value;
            REG_DIST_FRACTION: fade_cfg.dist_fraction = value;
            REG_BACK_EPS:      fade_cfg.back_eps      = value[EPS_W-1:0];
            default:           ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_settings(int unsigned border, int unsigned frac, int unsigned eps);
        wait_idle();
        write_reg(REG_EDGE_BORDER, CFG_W'(border));
        write_reg(REG_DIST_FRACTION, CFG_W'(frac));
        write_reg(REG_BACK_EPS, CFG_W'(eps));
    endtask

    task automatic test_field_extremes();
        tx_gaps      = 1'b0;
        rx_stall_pct = 0;
        send_pixel(make_pixel(8192, 8192, 0, -16384));
        send_pixel(make_pixel(-32768, 8192, 0, -16384));
        send_pixel(make_pixel(32767, 8192, 0, -16384));
        send_pixel(make_pixel(8192, -32768, 16384, -16384));
        send_pixel(make_pixel(8192, 32767, -32768, -16384));
        send_pixel(make_pixel(8192, 8192, 32767, -16384));
        send_pixel(make_pixel(8192, 8192, 13107, -16384));
        send_pixel(make_pixel(8192, 8192, 8192, 16384));
        send_pixel(make_pixel(8192, 8192, 8192, 0));
        send_pixel(make_pixel(8192, 8192, 8192, -164));
        send_pixel(make_pixel(8192, 8192, 8192, -165));
        send_pixel(make_pixel(8192, 8192, 8192, -4096));
        send_pixel(make_pixel(8192, 8192, 8192, -32768));
        send_pixel(make_pixel(8192, 8192, 8192, 32767));
        send_pixel(make_pixel(0, 0, 0, -16384));
        send_pixel(make_pixel(16384, 16384, 0, -16384));
        send_pixel(make_pixel(1638, 8192, 0, -16384));
        send_pixel(make_pixel(819, 8192, 0, -16384));
        send_pixel(make_pixel(8192, 16383, 0, -16384));
        send_pixel(make_pixel(-1, 16385, -1, -2000));
        send_pixel(make_pixel(1000, 15000, 15000, -1000));
        send_pixel(make_pixel(8191, 8193, 16383, -4097));
        wait_idle();
    endtask

    task automatic test_register_sweep();
        int unsigned borders[7] = '{0, 1, 16384, 32767, 16384, 0, 1638};
        int unsigned fracs[7]   = '{0, 1, 16384, 32767, 32767, 16384, 3277};
        int unsigned epsilons[7] = '{0, 4095, 4095, 0, 1, 32767, 164};
        tx_gaps      = 1'b1;
        rx_stall_pct = 25;
        for (int s = 0; s < 7; s++)
        begin
            apply_settings(borders[s], fracs[s], epsilons[s]);
            if (s == 6)
                write_reg(REG_UNUSED, CFG_W'(32767));
            for (int i = 0; i < 60; i++)
                send_pixel(random_pixel());
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 10; p++)
        begin
            apply_settings(random_setting(32767), random_setting(32767),
                           random_setting(32767));
            if (p % 4 == 3)
                write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 32767)));
            tx_gaps      = (p % 3 != 0);
            rx_stall_pct = (p % 5) * 15;
            for (int i = 0; i < 130; i++)
                send_pixel(random_pixel());
        end
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        apply_settings(1638, 3277, 164);
        tx_gaps      = 1'b0;
        rx_stall_pct = 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 120; i++)
            send_pixel(random_pixel());
        wait_idle();
        rx_stall_pct = 40;
        for (int i = 0; i < 80; i++)
            send_pixel(random_pixel());
        wait_idle();
    endtask

    always @(posedge clk)
    begin
        rx_pattern <= {rx_pattern[0], rx_pattern[7:1]};
        m_tready   <= !rx_hold && (rx_stall_pct == 0 || rx_pattern[0]
                                   || $urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_fades.size() == 0)
                report_mismatch("result with no request pending", '0,
                                m_tdata[VAL_W-1:0], '0);
            else
            begin
                head_req = pending_fades.pop_front();
                if (m_tdata[VAL_W-1:0] !== head_req.weight)
                    report_mismatch("fade_weight", head_req.px, m_tdata[VAL_W-1:0],
                                    head_req.weight);
            end
        end
    end

    initial
    begin
        fade_cfg.edge_border   = EDGE_BORDER_RST;
        fade_cfg.dist_fraction = DIST_FRACTION_RST;
        fade_cfg.back_eps      = BACK_EPS_RST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_register_sweep();
        test_random_traffic();
        test_output_backpressure();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("reflection_fade_factor verification clean");
        else
            $display("reflection_fade_factor verification failed");
        $finish;
    end

endmodule
